// ===== rtl/fpuv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpuv_pkg
// Shared constants and saturation helper for the FPU-alpha Verlet step block.
// ----------------------------------------------------------------------------
package fpuv_pkg;

  localparam int unsigned CHAIN_CAPACITY_DEF = 64;
  localparam int unsigned QW                 = 32;
  localparam int unsigned DTW                = 24;
  localparam int unsigned WW                 = 40;
  localparam logic [DTW-1:0] TIME_STEP_RESET = 24'd838861;

  // Clamp a wide signed value into Q8.24.
  function automatic logic signed [QW-1:0] sat32(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] hi;
    logic signed [WW-1:0] lo;
    hi = {{(WW-QW+1){1'b0}}, {(QW-1){1'b1}}};
    lo = {{(WW-QW+1){1'b1}}, {(QW-1){1'b0}}};
    if (v > hi) begin
      return hi[QW-1:0];
    end else if (v < lo) begin
      return lo[QW-1:0];
    end
    return v[QW-1:0];
  endfunction

  function automatic logic signed [WW-1:0] sx(input logic signed [QW-1:0] v);
    return {{(WW-QW){v[QW-1]}}, v};
  endfunction

endpackage

// ===== rtl/fpuv_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpuv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fpuv_ram import fpuv_pkg::*; #(
  parameter int unsigned WIDTH = QW,
  parameter int unsigned DEPTH = CHAIN_CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/fpu_alpha_chain_verlet_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpu_alpha_chain_verlet_step
// Loads a particle chain, runs one velocity Verlet step of the FPU-alpha
// chain (alpha 1/4, fixed ends) in signed Q8.24, then streams the chain out.
// ----------------------------------------------------------------------------
//
//  channel   dir  transfer when           payload
//  s_axis    in   tvalid & tready          tdata={momentum,position}, tlast=last
//  m_axis    out  tvalid & tready          tdata={new_momentum,new_position},
//                                          tlast=end_of_chain
//  cfg       in   cfg_valid_i & cfg_ready_o cfg_data_i = time_step
//
//  Loading stores one pair per transfer. After the last pair, two passes run
//  over the chain, one particle at a time, paced by the one shared 33x33
//  multiplier and the single read port of each store. Emit reads each pair
//  from the stores and then offers it. Reset clears the sequencer, the load
//  count and the output valid and loads the default time step; the stores
//  need no clearing. A stalled output holds; input is taken only while the
//  block is loading.
// ----------------------------------------------------------------------------
module fpu_alpha_chain_verlet_step import fpuv_pkg::*; #(
  parameter int unsigned CHAIN_CAPACITY = CHAIN_CAPACITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [63:0]    s_axis_tdata,   // [31:0] position, [63:32] momentum
  input  logic           s_axis_tlast,   // last
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [63:0]    m_axis_tdata,   // [31:0] new_position, [63:32] new_momentum
  output logic           m_axis_tlast,   // end_of_chain
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [DTW-1:0] cfg_data_i      // time_step
);

  localparam int unsigned AW = $clog2(CHAIN_CAPACITY);
  localparam int unsigned CW = $clog2(CHAIN_CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CHAIN_CAPACITY);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRIME, ST_RD, ST_DIF, ST_SQR, ST_SQL, ST_FRC, ST_KCK,
    ST_PUP, ST_DRM, ST_DRA, ST_WR, ST_ERD, ST_ELD
  } state_e;

  state_e  state_q;
  logic    pass2_q;
  logic [CW-1:0] cnt_q, n_q, i_q;
  logic [DTW-1:0] dt_q;

  logic signed [QW-1:0] l_q, m_q, r_q, p_q, dr_q, dl_q, f_q, d_q;
  logic signed [WW-1:0] acc_q;
  logic signed [65:0]   mul_q;
  logic signed [32:0]   mul_a, mul_b;

  logic [QW-1:0] pos_rd, mom_rd, dft_rd;
  logic          pos_we, mom_we, dft_we;
  logic [AW-1:0] pos_wa, mom_wa, pos_ra, mom_ra;
  logic [QW-1:0] mom_wd, dft_wd;
  logic          load_xfer, is_end;
  logic [CW-1:0] i_nx;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign load_xfer     = s_axis_tvalid && s_axis_tready;
  assign i_nx          = i_q + CW'(1);
  assign is_end        = (i_q == '0) || (i_q == n_q - CW'(1));

  // Store ports: load writes position and momentum; the passes own the rest.
  assign pos_we = load_xfer && (cnt_q < CAP);
  assign pos_wa = cnt_q[AW-1:0];
  assign mom_we = pos_we || (state_q == ST_WR);
  assign mom_wa = (state_q == ST_IDLE) ? cnt_q[AW-1:0] : i_q[AW-1:0];
  assign mom_wd = (state_q == ST_IDLE) ? s_axis_tdata[63:32] : p_q;
  assign dft_we = (state_q == ST_WR) && !pass2_q;
  assign dft_wd = is_end ? m_q : d_q;
  assign mom_ra = i_q[AW-1:0];
  always_comb begin
    pos_ra = i_nx[AW-1:0];
    if (state_q == ST_PRIME || state_q == ST_ERD || state_q == ST_ELD) begin
      pos_ra = i_q[AW-1:0];
    end
  end

  fpuv_ram #(.WIDTH(QW), .DEPTH(CHAIN_CAPACITY)) u_pos (
    .clk_i, .we_i(pos_we), .waddr_i(pos_wa), .wdata_i(s_axis_tdata[31:0]),
    .raddr_i(pos_ra), .rdata_o(pos_rd));
  fpuv_ram #(.WIDTH(QW), .DEPTH(CHAIN_CAPACITY)) u_mom (
    .clk_i, .we_i(mom_we), .waddr_i(mom_wa), .wdata_i(mom_wd),
    .raddr_i(mom_ra), .rdata_o(mom_rd));
  fpuv_ram #(.WIDTH(QW), .DEPTH(CHAIN_CAPACITY)) u_dft (
    .clk_i, .we_i(dft_we), .waddr_i(i_q[AW-1:0]), .wdata_i(dft_wd),
    .raddr_i(pos_ra), .rdata_o(dft_rd));

  // Shared multiplier operand select.
  always_comb begin
    mul_a = {dl_q[QW-1], dl_q};
    mul_b = {dl_q[QW-1], dl_q};
    unique case (state_q)
      ST_SQR: begin
        mul_a = {dr_q[QW-1], dr_q};
        mul_b = {dr_q[QW-1], dr_q};
      end
      ST_KCK: begin
        mul_a = {9'b0, dt_q};
        mul_b = {f_q[QW-1], f_q};
      end
      ST_DRM: begin
        mul_a = {9'b0, dt_q};
        mul_b = {p_q[QW-1], p_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pass2_q       <= 1'b0;
      cnt_q         <= '0;
      n_q           <= '0;
      i_q           <= '0;
      dt_q          <= TIME_STEP_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        dt_q <= cfg_data_i;
      end
      // Drop valid after a transfer unless the emit state reloads it.
      if (m_axis_tvalid && m_axis_tready && state_q != ST_ELD) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (load_xfer) begin
            if (s_axis_tlast) begin
              // Close the chain and start the first pass.
              n_q     <= (cnt_q < CAP) ? cnt_q + CW'(1) : cnt_q;
              cnt_q   <= '0;
              i_q     <= '0;
              pass2_q <= 1'b0;
              state_q <= ST_PRIME;
            end else if (cnt_q < CAP) begin
              cnt_q <= cnt_q + CW'(1);
            end
          end
        end
        ST_PRIME: state_q <= ST_RD;
        ST_RD: begin
          if (i_q == '0) begin
            m_q <= pass2_q ? dft_rd : pos_rd;
          end
          state_q <= ST_DIF;
        end
        ST_DIF: begin
          r_q     <= pass2_q ? dft_rd : pos_rd;
          p_q     <= mom_rd;
          dr_q    <= sat32(sx(pass2_q ? dft_rd : pos_rd) - sx(m_q));
          dl_q    <= sat32(sx(m_q) - sx(l_q));
          state_q <= is_end ? ST_WR : ST_SQR;
        end
        ST_SQR: state_q <= ST_SQL;
        ST_SQL: begin
          acc_q   <= sx(dr_q) + WW'($signed(mul_q[65:26]));
          state_q <= ST_FRC;
        end
        ST_FRC: begin
          f_q     <= sat32(acc_q - sx(dl_q) - WW'($signed(mul_q[65:26])));
          state_q <= ST_KCK;
        end
        ST_KCK: state_q <= ST_PUP;
        ST_PUP: begin
          p_q     <= sat32(sx(p_q) + $signed(mul_q[64:25]));
          state_q <= pass2_q ? ST_WR : ST_DRM;
        end
        ST_DRM: state_q <= ST_DRA;
        ST_DRA: begin
          d_q     <= sat32(sx(m_q) + $signed(mul_q[63:24]));
          state_q <= ST_WR;
        end
        ST_WR: begin
          // Slide the window and advance.
          l_q <= m_q;
          m_q <= r_q;
          if (i_q == n_q - CW'(1)) begin
            i_q     <= '0;
            pass2_q <= 1'b1;
            state_q <= pass2_q ? ST_ERD : ST_PRIME;
          end else begin
            i_q     <= i_nx;
            state_q <= ST_RD;
          end
        end
        ST_ERD: state_q <= ST_ELD;
        ST_ELD: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {mom_rd, dft_rd};
            m_axis_tlast  <= (i_q == n_q - CW'(1));
            if (i_q == n_q - CW'(1)) begin
              state_q <= ST_IDLE;
            end else begin
              i_q     <= i_nx;
              state_q <= ST_ERD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Load count never exceeds the capacity.
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CAP)
    else $error("load count above capacity");
  // The last pair closes the load phase at once.
  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
      load_xfer && s_axis_tlast |=> !s_axis_tready)
    else $error("input still open after last pair");
  // Drift store is written only during the first pass.
  a_dft_pass1: assert property (@(posedge clk_i) disable iff (!rst_ni)
      dft_we |-> !pass2_q && !s_axis_tready)
    else $error("drift write outside first pass");

endmodule
